>>> design/kae_pkg.sv
// Shared types and constants for the key auto-repeat and edge detect block.
// Used by the lane, the output stage and the top level; depends on nothing.
package kae_pkg;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int ELAPSED_BITS   = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_DELAY  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_PERIOD = 8'd1;

    localparam logic [CFG_DATA_BITS-1:0] REPEAT_DELAY_RESET  = 16'd400;
    localparam logic [CFG_DATA_BITS-1:0] REPEAT_PERIOD_RESET = 16'd180;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] repeat_delay_ms;
        logic [CFG_DATA_BITS-1:0] repeat_period_ms;
    } t_repeat_cfg;

endpackage

>>> design/kae_lane.sv
// One menu key lane: held time and repeat period counters with saturation.
// Depends on kae_pkg for the configuration struct and the elapsed time width.
module kae_lane
    import kae_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic                    i_key,
    input  logic [ELAPSED_BITS-1:0] i_elapsed_ms,
    input  t_repeat_cfg             i_cfg,
    output logic                    o_on
);

    // Compare and add width: wide enough for either operand plus a carry.
    localparam int CW = ((TIME_BITS > CFG_DATA_BITS) ? TIME_BITS : CFG_DATA_BITS) + 1;

    logic [TIME_BITS-1:0] r_held, n_held;
    logic [TIME_BITS-1:0] r_period, n_period;
    logic [CW-1:0]        held_sum, period_sum, dt_ext;
    logic [TIME_BITS-1:0] held_sat, period_sat;

    assign dt_ext     = CW'(i_elapsed_ms);
    assign held_sum   = CW'(r_held) + dt_ext;
    assign period_sum = CW'(r_period) + dt_ext;
    // Any bit above the time width means the count passed its maximum.
    assign held_sat   = (held_sum[CW-1:TIME_BITS] != '0) ? '1 : held_sum[TIME_BITS-1:0];
    assign period_sat = (period_sum[CW-1:TIME_BITS] != '0) ? '1 : period_sum[TIME_BITS-1:0];

    always_comb begin
        n_held   = r_held;
        n_period = r_period;
        o_on     = 1'b0;
        priority if (!i_key) begin
            n_held   = '0;
            n_period = '0;
        end else if (r_held == '0) begin
            o_on   = 1'b1;
            n_held = held_sat;
        end else if (CW'(r_held) < CW'(i_cfg.repeat_delay_ms)) begin
            n_held = held_sat;
        end else if (i_cfg.repeat_period_ms == '0) begin
            o_on = 1'b1;
        end else if (r_period == '0) begin
            o_on     = 1'b1;
            n_period = period_sat;
        end else if (CW'(r_period) < CW'(i_cfg.repeat_period_ms)) begin
            n_period = period_sat;
        end else begin
            n_period = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_period <= '0;
        end else if (i_fire) begin
            r_held   <= n_held;
            r_period <= n_period;
        end
    end

endmodule

>>> design/kae_merge.sv
// Merging stage: gathers the lane results and system pulses into one output
// word, held in a main register with a skid register behind it. Uses kae_pkg.
module kae_merge
    import kae_pkg::*;
#(
    parameter int MENU_KEY_COUNT   = 8,
    parameter int SYSTEM_KEY_COUNT = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [MENU_KEY_COUNT-1:0]   i_menu_active,
    input  logic [SYSTEM_KEY_COUNT-1:0] i_system_pulse,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [MENU_KEY_COUNT-1:0]   o_menu_active,
    output logic [SYSTEM_KEY_COUNT-1:0] o_system_pulse
);

    localparam int DW = MENU_KEY_COUNT + SYSTEM_KEY_COUNT;

    logic          r_main_valid, r_skid_valid;
    logic [DW-1:0] r_main, r_skid;
    logic          in_fire, out_fire;
    logic [DW-1:0] in_word;

    assign in_word  = {i_menu_active, i_system_pulse};
    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // No word is taken in while the skid is full.
                if (out_fire) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire) begin
                if (!r_main_valid || out_fire) begin
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_main_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_main <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_main_valid || out_fire) begin
                r_main <= in_word;
            end else begin
                r_skid <= in_word;
            end
        end
    end

    assign o_valid        = r_main_valid;
    assign o_menu_active  = r_main[DW-1:SYSTEM_KEY_COUNT];
    assign o_system_pulse = r_main[SYSTEM_KEY_COUNT-1:0];

endmodule

>>> design/key_autorepeat_edge_detect.sv
// Top level of the key auto-repeat and edge detect block.
// Instantiates one kae_lane per menu key and kae_merge; uses kae_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one update word per tick:
//   held level of the menu keys and system keys plus elapsed milliseconds.
//   Output channel (o_out_valid / i_out_stall) gives one result word per
//   update: the menu keys active this update with auto-repeat applied, and a
//   one-update pulse for each system key that was newly pressed.
//   The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) sets the
//   repeat delay (index 0) and the repeat period (index 1); other indexes
//   are ignored. Write it only while the block is idle.
// Timing:
//   A result is registered in the output stage, and one update can be
//   accepted every cycle while o_in_stall is low. Each menu key has its own
//   lane with its own adds and compares for the held and repeat timers.
//   The output register has a skid register behind it, so an update is still
//   taken while a result waits; o_in_stall rises only when both are full.
// Reset:
//   Clears all key timers and system key history, returns the registers to
//   a 400 ms delay and a 180 ms period, and empties the output stage.
module key_autorepeat_edge_detect
    import kae_pkg::*;
#(
    parameter int MENU_KEY_COUNT   = 8,
    parameter int SYSTEM_KEY_COUNT = 2,
    parameter int TIME_BITS        = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [MENU_KEY_COUNT-1:0]   i_menu_keys,
    input  logic [SYSTEM_KEY_COUNT-1:0] i_system_keys,
    input  logic [ELAPSED_BITS-1:0]     i_elapsed_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [MENU_KEY_COUNT-1:0]   o_menu_active,
    output logic [SYSTEM_KEY_COUNT-1:0] o_system_pulse
);

    t_repeat_cfg                 r_cfg;
    logic [SYSTEM_KEY_COUNT-1:0] r_system_held;
    logic [MENU_KEY_COUNT-1:0]   lane_on;
    logic [SYSTEM_KEY_COUNT-1:0] system_pulse;
    logic                        in_fire;

    assign in_fire = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay_ms  <= REPEAT_DELAY_RESET;
            r_cfg.repeat_period_ms <= REPEAT_PERIOD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_REPEAT_DELAY) begin
                r_cfg.repeat_delay_ms <= i_cfg_data;
            end else if (i_cfg_index == CFG_REPEAT_PERIOD) begin
                r_cfg.repeat_period_ms <= i_cfg_data;
            end
        end
    end

    // A system key pulses when it is held now and was released last update.
    assign system_pulse = i_system_keys & ~r_system_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_system_held <= '0;
        end else if (in_fire) begin
            r_system_held <= i_system_keys;
        end
    end

    for (genvar k = 0; k < MENU_KEY_COUNT; k++) begin : g_lane
        kae_lane #(
            .TIME_BITS(TIME_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_fire      (in_fire),
            .i_key       (i_menu_keys[k]),
            .i_elapsed_ms(i_elapsed_ms),
            .i_cfg       (r_cfg),
            .o_on        (lane_on[k])
        );
    end

    kae_merge #(
        .MENU_KEY_COUNT  (MENU_KEY_COUNT),
        .SYSTEM_KEY_COUNT(SYSTEM_KEY_COUNT)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_menu_active (lane_on),
        .i_system_pulse(system_pulse),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_menu_active (o_menu_active),
        .o_system_pulse(o_system_pulse)
    );

endmodule

>>> tb/key_autorepeat_edge_detect_checker.sv
`timescale 1ns / 1ps
// Checker for key_autorepeat_edge_detect: watches the configuration port and both
// word channels, predicts each result word and compares it field by field.
// Depends on kae_pkg for register indexes and reset values.
module key_autorepeat_edge_detect_checker
    import kae_pkg::*;
#(
    parameter int MENU_KEYS = 8,
    parameter int SYS_KEYS  = 2,
    parameter int TIME_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [MENU_KEYS-1:0]      i_menu_keys,
    input  logic [SYS_KEYS-1:0]       i_system_keys,
    input  logic [ELAPSED_BITS-1:0]   i_elapsed_ms,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [MENU_KEYS-1:0]      i_menu_active,
    input  logic [SYS_KEYS-1:0]       i_system_pulse,
    input  logic                      i_run_done,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked
);

    typedef struct packed {
        logic [MENU_KEYS-1:0] menu_active;
        logic [SYS_KEYS-1:0]  system_pulse;
    } t_key_result;

    localparam logic [32:0] TIME_CEIL = (33'd1 << TIME_BITS) - 33'd1;

    logic [CFG_DATA_BITS-1:0] rpt_delay;
    logic [CFG_DATA_BITS-1:0] rpt_period;
    logic [TIME_BITS-1:0]     hold_ms [MENU_KEYS];
    logic [TIME_BITS-1:0]     rep_ms  [MENU_KEYS];
    logic [SYS_KEYS-1:0]      sys_last;
    t_key_result              due_results [$];
    int                       error_total  = 0;
    int                       result_total = 0;
    bit                       leftover_checked = 1'b0;

    function automatic logic [TIME_BITS-1:0] add_clamped(input logic [TIME_BITS-1:0] acc,
                                                         input logic [ELAPSED_BITS-1:0] step);
        logic [32:0] total;
        total = 33'(acc) + 33'(step);
        return (total > TIME_CEIL) ? TIME_CEIL[TIME_BITS-1:0] : total[TIME_BITS-1:0];
    endfunction

    // Moves every key timer on by one update and returns the word it should produce.
    function automatic t_key_result advance_key_timers(input logic [MENU_KEYS-1:0] keys,
                                                       input logic [SYS_KEYS-1:0] sys,
                                                       input logic [ELAPSED_BITS-1:0] step);
        t_key_result res;
        res.menu_active = '0;
        for (int k = 0; k < MENU_KEYS; k++) begin
            if (!keys[k]) begin
                hold_ms[k] = '0;
                rep_ms[k]  = '0;
            end else if (hold_ms[k] == '0) begin
                res.menu_active[k] = 1'b1;
                hold_ms[k] = add_clamped(hold_ms[k], step);
            end else if (hold_ms[k] < rpt_delay) begin
                hold_ms[k] = add_clamped(hold_ms[k], step);
            end else if (rpt_period == '0) begin
                res.menu_active[k] = 1'b1;
            end else if (rep_ms[k] == '0) begin
                res.menu_active[k] = 1'b1;
                rep_ms[k] = add_clamped(rep_ms[k], step);
            end else if (rep_ms[k] < rpt_period) begin
                rep_ms[k] = add_clamped(rep_ms[k], step);
            end else begin
                // One quiet update closes the period before the next repeat.
                rep_ms[k] = '0;
            end
        end
        res.system_pulse = sys & ~sys_last;
        sys_last = sys;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        error_total++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_key_result want;
        if (!i_rst_n) begin
            rpt_delay  = REPEAT_DELAY_RESET;
            rpt_period = REPEAT_PERIOD_RESET;
            for (int k = 0; k < MENU_KEYS; k++) begin
                hold_ms[k] = '0;
                rep_ms[k]  = '0;
            end
            sys_last = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_REPEAT_DELAY) begin
                    rpt_delay = i_cfg_data;
                end else if (i_cfg_index == CFG_REPEAT_PERIOD) begin
                    rpt_period = i_cfg_data;
                end
            end
            // Results leave before the new word is predicted, so a stray result
            // cannot pair with a word accepted in the same cycle.
            if (i_out_valid && !i_out_stall) begin
                result_total++;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result word %h/%h arrived with none expected",
                                              i_menu_active, i_system_pulse));
                end else begin
                    want = due_results.pop_front();
                    if (i_menu_active !== want.menu_active) begin
                        report_mismatch($sformatf("menu_active %h, expected %h",
                                                  i_menu_active, want.menu_active));
                    end
                    if (i_system_pulse !== want.system_pulse) begin
                        report_mismatch($sformatf("system_pulse %h, expected %h",
                                                  i_system_pulse, want.system_pulse));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due_results.push_back(advance_key_timers(i_menu_keys, i_system_keys,
                                                         i_elapsed_ms));
            end
            if (i_run_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (due_results.size() != 0) begin
                    report_mismatch($sformatf("%0d result words never arrived",
                                              due_results.size()));
                end
            end
        end
        o_errors  <= error_total;
        o_pending <= due_results.size();
        o_checked <= result_total;
    end

endmodule

>>> tb/key_autorepeat_edge_detect_test.sv
`timescale 1ns / 1ps
// Top of the key_autorepeat_edge_detect testbench: clock, reset, register writes,
// update words and result back-pressure. Uses kae_pkg and the checker module.
module key_autorepeat_edge_detect_test;
    import kae_pkg::*;

    localparam int MENU_KEYS   = 8;
    localparam int SYS_KEYS    = 2;
    localparam int TIME_BITS   = 16;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_WAIT    = 19;
    localparam int QUIET_LIMIT = 1000;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_LAST = '1;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [MENU_KEYS-1:0]      menu_keys;
    logic [SYS_KEYS-1:0]       system_keys;
    logic [ELAPSED_BITS-1:0]   elapsed_ms;
    logic                      out_valid;
    logic                      out_stall;
    logic [MENU_KEYS-1:0]      menu_active;
    logic [SYS_KEYS-1:0]       system_pulse;
    logic                      run_done;
    int                        err_count;
    int                        pending;
    int                        checked;
    bit                        src_idle;
    bit                        sink_idle;
    int                        updates_sent;
    int                        writes_done;
    int                        quiet_cycles = 0;

    always #4 clk = ~clk;

    key_autorepeat_edge_detect #(
        .MENU_KEY_COUNT   (MENU_KEYS),
        .SYSTEM_KEY_COUNT (SYS_KEYS),
        .TIME_BITS        (TIME_BITS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_menu_keys    (menu_keys),
        .i_system_keys  (system_keys),
        .i_elapsed_ms   (elapsed_ms),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_menu_active  (menu_active),
        .o_system_pulse (system_pulse)
    );

    key_autorepeat_edge_detect_checker #(
        .MENU_KEYS (MENU_KEYS),
        .SYS_KEYS  (SYS_KEYS),
        .TIME_BITS (TIME_BITS)
    ) activity_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_menu_keys    (menu_keys),
        .i_system_keys  (system_keys),
        .i_elapsed_ms   (elapsed_ms),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_menu_active  (menu_active),
        .i_system_pulse (system_pulse),
        .i_run_done     (run_done),
        .o_errors       (err_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Ends the run if no word moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d cycles with no word moving", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Result side: after each accepted word, while sink_idle is set, hold stall for a drawn number of cycles.
    initial begin
        int hold;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall) begin
                hold = sink_idle ? $urandom_range(0, MAX_WAIT) : 0;
                if (hold > 0) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so back-to-back words never drop it.
    task automatic send_update(input logic [MENU_KEYS-1:0] keys, input logic [SYS_KEYS-1:0] sys,
                               input logic [ELAPSED_BITS-1:0] step);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        menu_keys   <= keys;
        system_keys <= sys;
        elapsed_ms  <= step;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        updates_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_BITS-1:0] delay_ms,
                                  input logic [CFG_DATA_BITS-1:0] period_ms);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REPEAT_DELAY;
        cfg_data  <= delay_ms;
        @(negedge clk);
        cfg_index <= CFG_REPEAT_PERIOD;
        cfg_data  <= period_ms;
        @(negedge clk);
        // An index past the register list must leave both settings alone.
        cfg_index <= CFG_INDEX_BITS'($urandom_range(int'(CFG_REPEAT_PERIOD) + 1,
                                                    int'(CFG_INDEX_LAST)));
        cfg_data  <= CFG_DATA_BITS'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        writes_done += 3;
    endtask

    initial begin
        logic [MENU_KEYS-1:0]     held_level;
        logic [MENU_KEYS-1:0]     keys;
        logic [SYS_KEYS-1:0]      sys_level;
        logic [ELAPSED_BITS-1:0]  step;
        logic [CFG_DATA_BITS-1:0] delay_set;
        logic [CFG_DATA_BITS-1:0] period_set;
        int                       scale;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        menu_keys    = '0;
        system_keys  = '0;
        elapsed_ms   = '0;
        run_done     = 1'b0;
        held_level   = '0;
        sys_level    = '0;
        updates_sent = 0;
        writes_done  = 0;
        {sink_idle, src_idle} = 2'($urandom_range(0, 3));
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset settings: zero elapsed time keeps fresh
        // presses pulsing, full-scale steps saturate both timers, then edges on
        // the system keys and one key walked through delay and repeats.
        send_update(8'h00, 2'b00, 16'h0000);
        send_update(8'hFF, 2'b11, 16'h0000);
        send_update(8'hFF, 2'b11, 16'h0000);
        send_update(8'h00, 2'b00, 16'hFFFF);
        send_update(8'hFF, 2'b01, 16'hFFFF);
        send_update(8'hFF, 2'b01, 16'hFFFF);
        send_update(8'hFF, 2'b10, 16'hFFFF);
        send_update(8'hFF, 2'b10, 16'h0001);
        send_update(8'hAA, 2'b00, 16'd100);
        send_update(8'h55, 2'b11, 16'h5555);
        send_update(8'hAA, 2'b00, 16'hAAAA);
        send_update(8'h55, 2'b01, 16'h0001);
        send_update(8'hFF, 2'b10, 16'd200);
        send_update(8'hFF, 2'b00, 16'd200);
        send_update(8'hFF, 2'b00, 16'd200);
        send_update(8'h00, 2'b11, 16'h0000);
        repeat (9) send_update(8'h01, 2'b00, 16'd100);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin delay_set = 16'd400;   period_set = 16'd180;   end
                1: begin delay_set = 16'd20;    period_set = 16'd6;     end
                2: begin delay_set = 16'd0;     period_set = 16'd0;     end
                3: begin delay_set = 16'hFFFF;  period_set = 16'hFFFF;  end
                4: begin delay_set = 16'd12;    period_set = 16'd0;     end
                5: begin delay_set = 16'd0;     period_set = 16'hFFFF;  end
                6: begin delay_set = 16'd30;    period_set = 16'd1;     end
                default: begin
                    delay_set  = CFG_DATA_BITS'($urandom);
                    period_set = CFG_DATA_BITS'($urandom);
                end
            endcase
            wait_results_drained();
            write_settings(delay_set, period_set);
            // Steps scaled to the settings so keys reach the repeat phase while held.
            scale = int'(delay_set >> 3) + int'(period_set >> 1) + 2;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    {sink_idle, src_idle} = 2'($urandom_range(0, 3));
                end
                if (n == PHASE_ITEMS / 2 && phase % 2 == 1) begin
                    wait_results_drained();
                end
                for (int k = 0; k < MENU_KEYS; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        held_level[k] = ~held_level[k];
                    end
                end
                sys_level ^= SYS_KEYS'($urandom) & SYS_KEYS'($urandom);
                keys = ($urandom_range(0, 9) == 0) ? MENU_KEYS'($urandom) : held_level;
                case ($urandom_range(0, 31))
                    0, 1:    step = '0;
                    2:       step = '1;
                    3, 4:    step = ELAPSED_BITS'($urandom);
                    default: step = ELAPSED_BITS'($urandom_range(1, scale));
                endcase
                send_update(keys, sys_level, step);
            end
        end

        wait_results_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        run_done <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Sent %0d key updates and %0d register writes; %0d result words compared.",
                 updates_sent, writes_done, checked);
        $display("Repeat delay and period swept over zero, small values, defaults and full scale.");
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
